@@ hw/rtl/stgs_pkg.sv @@
// Shared types and constants for the rolling window cell store.
package stgs_pkg;

    localparam int ROWS_DEF      = 64;
    localparam int COLS_DEF      = 64;
    localparam int CELL_BITS_DEF = 8;

    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_RECENTER = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] local_row;
        logic signed [15:0] local_col;
        logic [7:0]         write_value;
        logic signed [23:0] center_world_row;
        logic signed [23:0] center_world_col;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cell_value;
        logic       in_range;
        logic       moved;
    } out_item_t;

    // Back end engine states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FILL_ROW,
        ST_FILL_COL,
        ST_FILL_ALL,
        ST_RESULT
    } be_state_t;

endpackage

@@ hw/rtl/stgs_front.sv @@
// Front end: accepts items, holds them in a short queue for the back end.
module stgs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  stgs_pkg::in_item_t  in_item,
    output logic                q_valid,
    input  logic                q_ready,
    output stgs_pkg::in_item_t  q_item
);
    import stgs_pkg::*;

    localparam int DEPTH = 2;

    in_item_t    mem_reg [DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

@@ hw/rtl/stgs_back.sv @@
// Back end: carries out reads, writes, recenter strip fills and clears on the store.
module stgs_back #(
    parameter int ROWS      = stgs_pkg::ROWS_DEF,
    parameter int COLS      = stgs_pkg::COLS_DEF,
    parameter int CELL_BITS = stgs_pkg::CELL_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          fill_value,
    input  logic                q_valid,
    output logic                q_ready,
    input  stgs_pkg::in_item_t  q_item,
    output logic                out_valid,
    input  logic                out_ready,
    output stgs_pkg::out_item_t out_item,
    output logic                busy
);
    import stgs_pkg::*;

    localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CB    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int NC    = ROWS * COLS;
    localparam int AB    = $clog2(NC);
    localparam int CVB   = (CELL_BITS < 8) ? CELL_BITS : 8;
    localparam logic [23:0] HALF_R = 24'(ROWS / 2);
    localparam logic [23:0] HALF_C = 24'(COLS / 2);
    localparam logic [RB-1:0] RMAX = RB'(ROWS - 1);
    localparam logic [CB-1:0] CMAX = CB'(COLS - 1);
    localparam logic [AB-1:0] AMAX = AB'(NC - 1);

    logic [CELL_BITS-1:0] store [NC];

    be_state_t state_reg, state_next;
    logic [23:0] org_r_reg, org_c_reg;
    logic [RB-1:0] off_r_reg;
    logic [CB-1:0] off_c_reg;
    logic [23:0] dr_reg, dc_reg;          // remaining strip counts (magnitudes)
    logic        dr_neg_reg, dc_neg_reg;
    logic [RB-1:0] fill_r_reg;            // row being filled
    logic [CB-1:0] fill_c_reg;            // column being filled
    logic [AB-1:0] sweep_reg;             // position within a strip or full sweep
    logic          clear_pending_reg;     // clearing pass after reset
    out_item_t     res_reg;
    logic          res_valid_reg;
    logic [CELL_BITS-1:0] rd_data_reg;

    logic [CELL_BITS-1:0] fill_cell;
    assign fill_cell = CELL_BITS'(fill_value);

    // Recenter shift computation
    logic [23:0] cr, cc, dr, dc, ar, ac;
    assign cr = q_item.center_world_row - HALF_R;
    assign cc = q_item.center_world_col - HALF_C;
    assign dr = cr - org_r_reg;
    assign dc = cc - org_c_reg;
    assign ar = dr[23] ? (24'd0 - dr) : dr;
    assign ac = dc[23] ? (24'd0 - dc) : dc;

    // Local address mapping
    logic        acc_in;
    logic [RB:0] pr_sum;
    logic [CB:0] pc_sum;
    logic [RB-1:0] pr;
    logic [CB-1:0] pc;
    assign acc_in = !q_item.local_row[15] && !q_item.local_col[15]
                 && (32'(q_item.local_row) < 32'(ROWS))
                 && (32'(q_item.local_col) < 32'(COLS));
    assign pr_sum = {1'b0, q_item.local_row[RB-1:0]} + {1'b0, off_r_reg};
    assign pc_sum = {1'b0, q_item.local_col[CB-1:0]} + {1'b0, off_c_reg};
    assign pr = (pr_sum >= (RB+1)'(ROWS)) ? RB'(pr_sum - (RB+1)'(ROWS)) : pr_sum[RB-1:0];
    assign pc = (pc_sum >= (CB+1)'(COLS)) ? CB'(pc_sum - (CB+1)'(COLS)) : pc_sum[CB-1:0];

    logic [AB-1:0] acc_addr;
    assign acc_addr = AB'(32'(pr) * 32'(COLS) + 32'(pc));

    logic take;
    assign take    = (state_reg == ST_IDLE) && q_valid && !res_valid_reg && !clear_pending_reg;
    assign q_ready = take;
    assign busy    = (state_reg != ST_IDLE) || res_valid_reg || clear_pending_reg || q_valid;

    // Strip sweep helpers
    logic [RB-1:0] row_prev;
    logic [CB-1:0] col_prev;
    assign row_prev = (off_r_reg == '0) ? RMAX : off_r_reg - 1'b1;
    assign col_prev = (off_c_reg == '0) ? CMAX : off_c_reg - 1'b1;

    logic [AB-1:0] row_addr, col_addr;
    assign row_addr = AB'(32'(fill_r_reg) * 32'(COLS) + 32'(sweep_reg));
    assign col_addr = AB'(32'(sweep_reg) * 32'(COLS) + 32'(fill_c_reg));

    logic row_last, col_last;
    assign row_last = (sweep_reg == AB'(COLS - 1));
    assign col_last = (sweep_reg == AB'(ROWS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (op_t'(q_item.opcode))
                        OP_READ:     state_next = acc_in ? ST_READ : ST_RESULT;
                        OP_WRITE:    state_next = ST_RESULT;
                        OP_CLEAR:    state_next = ST_FILL_ALL;
                        OP_RECENTER:
                        begin
                            if (dr == '0 && dc == '0)
                                state_next = ST_RESULT;
                            else if (ar >= 24'(ROWS) || ac >= 24'(COLS))
                                state_next = ST_FILL_ALL;
                            else if (ar != '0)
                                state_next = ST_FILL_ROW;
                            else
                                state_next = ST_FILL_COL;
                        end
                        default:     state_next = ST_RESULT;
                    endcase
                end
            end
            ST_READ:     state_next = ST_RESULT;
            ST_FILL_ROW:
                if (row_last && dr_reg == 24'd1)
                    state_next = (dc_reg != '0) ? ST_FILL_COL : ST_RESULT;
            ST_FILL_COL:
                if (col_last && dc_reg == 24'd1)
                    state_next = ST_RESULT;
            ST_FILL_ALL:
                if (sweep_reg == AMAX)
                    state_next = ST_RESULT;
            ST_RESULT:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            org_r_reg         <= '0;
            org_c_reg         <= '0;
            off_r_reg         <= '0;
            off_c_reg         <= '0;
            sweep_reg         <= '0;
            clear_pending_reg <= 1'b1;
            res_valid_reg     <= 1'b0;
            res_reg           <= '0;
            dr_reg            <= '0;
            dc_reg            <= '0;
            dr_neg_reg        <= 1'b0;
            dc_neg_reg        <= 1'b0;
            fill_r_reg        <= '0;
            fill_c_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && out_ready)
                res_valid_reg <= 1'b0;
            if (clear_pending_reg)
            begin
                sweep_reg <= sweep_reg + 1'b1;
                if (sweep_reg == AMAX)
                begin
                    clear_pending_reg <= 1'b0;
                    sweep_reg         <= '0;
                end
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        res_reg.cell_value <= '0;
                        res_reg.in_range   <= (q_item.opcode == OP_READ
                                            || q_item.opcode == OP_WRITE) && acc_in;
                        res_reg.moved      <= (q_item.opcode == OP_RECENTER)
                                            && !(dr == '0 && dc == '0);
                        sweep_reg    <= '0;
                        dr_reg       <= ar;
                        dc_reg       <= ac;
                        dr_neg_reg   <= dr[23];
                        dc_neg_reg   <= dc[23];
                        fill_r_reg   <= dr[23] ? row_prev : off_r_reg;
                        fill_c_reg   <= dc[23] ? col_prev : off_c_reg;
                        if (q_item.opcode == OP_RECENTER && !(dr == '0 && dc == '0))
                        begin
                            org_r_reg <= cr;
                            org_c_reg <= cc;
                            if (ar >= 24'(ROWS) || ac >= 24'(COLS))
                            begin
                                off_r_reg <= '0;
                                off_c_reg <= '0;
                            end
                        end
                    end
                end
                ST_READ:
                    res_reg.cell_value <= 8'(rd_data_reg[CVB-1:0]);
                ST_FILL_ROW:
                begin
                    sweep_reg <= row_last ? '0 : sweep_reg + 1'b1;
                    if (row_last)
                    begin
                        dr_reg <= dr_reg - 1'b1;
                        if (dr_neg_reg)
                        begin
                            off_r_reg  <= fill_r_reg;
                            fill_r_reg <= (fill_r_reg == '0) ? RMAX : fill_r_reg - 1'b1;
                        end
                        else
                        begin
                            off_r_reg  <= (fill_r_reg == RMAX) ? '0 : fill_r_reg + 1'b1;
                            fill_r_reg <= (fill_r_reg == RMAX) ? '0 : fill_r_reg + 1'b1;
                        end
                    end
                end
                ST_FILL_COL:
                begin
                    sweep_reg <= col_last ? '0 : sweep_reg + 1'b1;
                    if (col_last)
                    begin
                        dc_reg <= dc_reg - 1'b1;
                        if (dc_neg_reg)
                        begin
                            off_c_reg  <= fill_c_reg;
                            fill_c_reg <= (fill_c_reg == '0) ? CMAX : fill_c_reg - 1'b1;
                        end
                        else
                        begin
                            off_c_reg  <= (fill_c_reg == CMAX) ? '0 : fill_c_reg + 1'b1;
                            fill_c_reg <= (fill_c_reg == CMAX) ? '0 : fill_c_reg + 1'b1;
                        end
                    end
                end
                ST_FILL_ALL:
                    sweep_reg <= sweep_reg + 1'b1;
                ST_RESULT:
                    res_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Cell store: one write port, one registered read port
    logic                 we;
    logic [AB-1:0]        waddr;
    logic [CELL_BITS-1:0] wdata;
    always_comb
    begin
        we    = 1'b0;
        waddr = sweep_reg;
        wdata = fill_cell;
        if (clear_pending_reg)
        begin
            // reset contents are zero, as the reset fill value is, not a later write
            we    = 1'b1;
            wdata = '0;
        end
        else if (state_reg == ST_FILL_ALL)
            we = 1'b1;
        else if (state_reg == ST_FILL_ROW)
        begin
            we    = 1'b1;
            waddr = row_addr;
        end
        else if (state_reg == ST_FILL_COL)
        begin
            we    = 1'b1;
            waddr = col_addr;
        end
        else if (take && q_item.opcode == OP_WRITE && acc_in)
        begin
            we    = 1'b1;
            waddr = acc_addr;
            wdata = CELL_BITS'(q_item.write_value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            store[waddr] <= wdata;
        rd_data_reg <= store[acc_addr];
    end

    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

endmodule

@@ hw/rtl/scrolling_toroidal_grid_store_core.sv @@
// Top level of the rolling window cell store.
// A ROWS x COLS ring-addressed cell store. Reads and writes pass one at a time through
// the back end engine; a read also goes through the registered store read. A recenter
// fills each entering row and column one cell per cycle; a large shift or a clear
// sweeps all ROWS*COLS cells. After reset a clearing pass over all ROWS*COLS cells
// runs before the first item is carried out. A two-entry queue decouples input
// acceptance from the engine.
module scrolling_toroidal_grid_store_core #(
    parameter int ROWS      = stgs_pkg::ROWS_DEF,
    parameter int COLS      = stgs_pkg::COLS_DEF,
    parameter int CELL_BITS = stgs_pkg::CELL_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  stgs_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output stgs_pkg::out_item_t out_item
);
    import stgs_pkg::*;

    logic [7:0] fill_value_reg;
    logic       q_valid, q_ready, busy;
    in_item_t   q_item;

    // Fill value register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_value_reg <= '0;
        else if (cfg_we)
            fill_value_reg <= cfg_wdata;
    end

    stgs_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    stgs_back #(.ROWS(ROWS), .COLS(COLS), .CELL_BITS(CELL_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .fill_value(fill_value_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .busy(busy)
    );

    // Checks
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result dropped while stalled");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("pending result without busy");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.in_range && out_item.moved))
        else $error("in_range and moved both set");

endmodule
